// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the tile packer RTL.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge outside reset.
`define PTBP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true outside reset.
`define PTBP_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- rtl/ptbp_pkg.sv -----
// Constants for the planar tile bitplane packer.
// No dependencies; imported by the top level.
package ptbp_pkg;

    // Tile geometry
    localparam int TILE_PIXELS = 64;
    localparam int TILE_COLS   = 8;
    localparam int PIX_W       = 8;
    localparam int ADDR_W      = $clog2(TILE_PIXELS);
    localparam int COL_W       = $clog2(TILE_COLS);

    // plane_mode register codes
    localparam logic [1:0] MODE_2PLANE = 2'd0;
    localparam logic [1:0] MODE_4PLANE = 2'd1;
    localparam logic [1:0] MODE_8PLANE = 2'd2;
    localparam logic [1:0] MODE_PACKED = 2'd3;
    localparam logic [1:0] MODE_RESET  = MODE_4PLANE;

    // Input op codes
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_BLANK = 1'b1;

    // Index of the final byte of a tile for each mode
    localparam logic [ADDR_W-1:0] LAST_2PLANE = ADDR_W'(2 * TILE_COLS - 1);
    localparam logic [ADDR_W-1:0] LAST_4PLANE = ADDR_W'(4 * TILE_COLS - 1);
    localparam logic [ADDR_W-1:0] LAST_8PLANE = ADDR_W'(8 * TILE_COLS - 1);
    localparam logic [ADDR_W-1:0] LAST_PACKED = ADDR_W'(TILE_PIXELS - 1);

endpackage

// ----- rtl/ptbp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the tile store.
module ptbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- rtl/planar_tile_bitplane_packer.sv -----
// Top level of the planar tile bitplane packer.
// Depends on ptbp_pkg, ptbp_ram and assert_macros.svh.
//
// Pixels of an 8x8 tile arrive in row-major order, one per cycle, and are
// written to a 64-entry tile store. The 64th pixel starts emission of the
// tile; no input is taken until the last byte has gone into the output
// register. All pixel reads go through the single read port of the tile
// store, so a planar row pair reads the 8 pixels of its row one by one and
// captures each before its two output bytes, and a packed byte is read and
// captured before its output. A blank tile emits one byte per cycle while
// the output is not stalled.
module planar_tile_bitplane_packer (
    input  logic       clk,
    input  logic       rst_n,
    // configuration write: plane_mode in [1:0]
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_data,
    // input stream
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [ptbp_pkg::PIX_W-1:0] s_axis_tdata,  // [7:0] pixel
    input  logic       s_axis_tuser,                  // [0] op
    // output stream
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [ptbp_pkg::PIX_W-1:0] m_axis_tdata,  // [7:0] out_byte
    output logic       m_axis_tlast                   // last
);

    import ptbp_pkg::*;

`include "assert_macros.svh"

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GATHER,
        ST_PUT
    } state_t;

    state_t              state_reg;
    logic [1:0]          plane_mode_reg;
    logic [ADDR_W-1:0]   pixel_count_reg;
    logic [ADDR_W-1:0]   byte_cnt_reg;
    logic [COL_W:0]      col_reg;
    logic                rd_pend_reg;
    logic                blank_reg;
    logic [PIX_W-1:0]    acc_lo_reg;
    logic [PIX_W-1:0]    acc_hi_reg;
    logic                out_valid_reg;
    logic [PIX_W-1:0]    out_byte_reg;
    logic                out_last_reg;

    logic                in_req;
    logic                packed_mode;
    logic [COL_W:0]      gather_len;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic [PIX_W-1:0]    rd_data;
    logic [COL_W-1:0]    plane_lo;
    logic [COL_W-1:0]    plane_hi;
    logic                last_byte;
    logic                out_free;
    logic [PIX_W-1:0]    put_byte;

    // Handshakes
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign in_req        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tlast  = out_last_reg;

    // Read sequencing: 8 pixels per planar row, one pixel per packed byte
    assign packed_mode = (plane_mode_reg == MODE_PACKED);
    assign gather_len  = packed_mode ? (COL_W+1)'(1) : (COL_W+1)'(TILE_COLS);
    assign rd_en       = (state_reg == ST_GATHER) && (col_reg < gather_len);
    assign rd_addr     = packed_mode ? byte_cnt_reg
                                     : {byte_cnt_reg[3:1], col_reg[COL_W-1:0]};

    // Plane pair from the byte index: pair in bits [5:4]
    assign plane_lo = {byte_cnt_reg[5:4], 1'b0};
    assign plane_hi = {byte_cnt_reg[5:4], 1'b1};

    // Final byte of the run
    always_comb
    begin
        case (plane_mode_reg)
            MODE_2PLANE: last_byte = (byte_cnt_reg == LAST_2PLANE);
            MODE_4PLANE: last_byte = (byte_cnt_reg == LAST_4PLANE);
            MODE_8PLANE: last_byte = (byte_cnt_reg == LAST_8PLANE);
            default:     last_byte = (byte_cnt_reg == LAST_PACKED);
        endcase
    end

    // Byte to present: 0 if blank, packed pixel, else lo plane even, hi odd
    always_comb
    begin
        if (blank_reg)
        begin
            put_byte = '0;
        end
        else if (packed_mode || !byte_cnt_reg[0])
        begin
            put_byte = acc_lo_reg;
        end
        else
        begin
            put_byte = acc_hi_reg;
        end
    end

    ptbp_ram #(
        .WIDTH (PIX_W),
        .DEPTH (TILE_PIXELS)
    ) u_tile_store (
        .clk     (clk),
        .wr_en   (in_req && (s_axis_tuser == OP_PIXEL)),
        .wr_addr (pixel_count_reg),
        .wr_data (s_axis_tdata),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Sequencer, shift unit and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            plane_mode_reg  <= MODE_RESET;
            pixel_count_reg <= '0;
            byte_cnt_reg    <= '0;
            col_reg         <= '0;
            rd_pend_reg     <= 1'b0;
            blank_reg       <= 1'b0;
            acc_lo_reg      <= '0;
            acc_hi_reg      <= '0;
            out_valid_reg   <= 1'b0;
            out_byte_reg    <= '0;
            out_last_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                plane_mode_reg <= cfg_data;
            end

            // Output register: loaded from ST_PUT, emptied when taken
            if ((state_reg == ST_PUT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            rd_pend_reg <= rd_en;

            case (state_reg)
                ST_IDLE:
                begin
                    byte_cnt_reg <= '0;
                    col_reg      <= '0;
                    if (in_req)
                    begin
                        if (s_axis_tuser == OP_BLANK)
                        begin
                            blank_reg <= 1'b1;
                            state_reg <= ST_PUT;
                        end
                        else
                        begin
                            pixel_count_reg <= pixel_count_reg + 1'b1;
                            if (pixel_count_reg == LAST_PACKED)
                            begin
                                blank_reg <= 1'b0;
                                state_reg <= ST_GATHER;
                            end
                        end
                    end
                end

                ST_GATHER:
                begin
                    if (rd_en)
                    begin
                        col_reg <= col_reg + 1'b1;
                    end
                    // capture the pixel read in the previous cycle
                    if (rd_pend_reg)
                    begin
                        if (packed_mode)
                        begin
                            acc_lo_reg <= rd_data;
                        end
                        else
                        begin
                            acc_lo_reg <= {acc_lo_reg[PIX_W-2:0], rd_data[plane_lo]};
                            acc_hi_reg <= {acc_hi_reg[PIX_W-2:0], rd_data[plane_hi]};
                        end
                        if (col_reg == gather_len)
                        begin
                            state_reg <= ST_PUT;
                        end
                    end
                end

                ST_PUT:
                begin
                    if (out_free)
                    begin
                        out_byte_reg  <= put_byte;
                        out_last_reg  <= last_byte;
                        byte_cnt_reg  <= byte_cnt_reg + 1'b1;
                        col_reg       <= '0;
                        if (last_byte)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else if (!blank_reg && (packed_mode || byte_cnt_reg[0]))
                        begin
                            state_reg <= ST_GATHER;
                        end
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Checks on the sequencer
    `PTBP_ASSERT(a_full_tile_starts_read, clk, rst_n,
        in_req && (s_axis_tuser == OP_PIXEL) && (pixel_count_reg == LAST_PACKED)
        |=> (state_reg == ST_GATHER) && (pixel_count_reg == '0),
        "full tile did not start emission")
    `PTBP_ASSERT(a_blank_starts_put, clk, rst_n,
        in_req && (s_axis_tuser == OP_BLANK) |=> (state_reg == ST_PUT) && blank_reg,
        "blank tile request did not start output")
    `PTBP_NEVER(a_col_overrun, clk, rst_n,
        (state_reg == ST_GATHER) && (col_reg > gather_len),
        "row read counter ran past row length")
    `PTBP_NEVER(a_stray_read, clk, rst_n,
        rd_pend_reg && (state_reg == ST_IDLE),
        "tile store read outstanding while idle")

endmodule
